// ===== design/spq_pkg.sv =====
// Shared types, widths and command codes for the sorted priority queue with prune.
package spq_pkg;

  localparam int KEY_BITS   = 32;
  localparam int TAG_BITS   = 16;
  localparam int COUNT_BITS = 7;
  localparam int DEPTH_DEF  = 64;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_PRUNE  = 2'd2;

  typedef struct packed {
    logic [1:0]                 command;
    logic signed [KEY_BITS-1:0] primary_key;
    logic signed [KEY_BITS-1:0] secondary_key;
    logic [TAG_BITS-1:0]        entry_tag;
    logic signed [KEY_BITS-1:0] bound_value;
  } spq_in_t;

  typedef struct packed {
    logic                       head_valid;
    logic [TAG_BITS-1:0]        head_tag;
    logic signed [KEY_BITS-1:0] head_primary;
    logic signed [KEY_BITS-1:0] head_secondary;
    logic [COUNT_BITS-1:0]      entry_count;
    logic                       overflow;
  } spq_out_t;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] primary;
    logic signed [KEY_BITS-1:0] secondary;
    logic [TAG_BITS-1:0]        tag;
  } spq_entry_t;

  // broadcast to every cell for the word being accepted
  typedef struct packed {
    logic [1:0]                 cmd;
    spq_entry_t                 entry;
    logic signed [KEY_BITS-1:0] bound;
  } spq_ctrl_t;

endpackage

// ===== design/spq_cell.sv =====
// One queue cell: holds an entry, compares it with the broadcast key, shifts with neighbors.
module spq_cell import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  spq_ctrl_t                    ctrl_i,
  input  logic [$clog2(DEPTH+1)-1:0]   count_i,
  input  spq_entry_t                   left_entry_i,
  input  logic                         left_gt_i,
  input  logic                         left_lt_i,
  input  spq_entry_t                   right_entry_i,
  output spq_entry_t                   entry_o,
  output logic                         gt_o,
  output logic                         lt_o,
  output logic                         cut_o
);

  localparam int CNT_W = $clog2(DEPTH+1);

  spq_entry_t entry_q, entry_d;
  logic       occ;

  assign occ = (count_i > CNT_W'(IDX));

  // lexicographic (primary, secondary) greater-than against the new entry
  assign gt_o = occ && (($signed(entry_q.primary) > $signed(ctrl_i.entry.primary)) ||
                        (($signed(entry_q.primary) == $signed(ctrl_i.entry.primary)) &&
                         ($signed(entry_q.secondary) > $signed(ctrl_i.entry.secondary))));

  assign lt_o  = ($signed(entry_q.primary) < $signed(ctrl_i.bound));
  // first held entry at or above the prune bound
  assign cut_o = occ && !lt_o && left_lt_i;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (left_gt_i) begin
          entry_d = left_entry_i;
        end else if (gt_o || !occ) begin
          entry_d = ctrl_i.entry;
        end
      end
      CMD_POP: begin
        entry_d = right_entry_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== design/spq_cut_enc.sv =====
// Turns the one-hot prune boundary flags of the cell row into a cell index.
module spq_cut_enc import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic [DEPTH-1:0]             cut_i,
  output logic                         any_o,
  output logic [$clog2(DEPTH+1)-1:0]   idx_o
);

  localparam int CNT_W = $clog2(DEPTH+1);

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cut_i[i]) begin
        idx_o = idx_o | CNT_W'(i);
      end
    end
  end

  assign any_o = |cut_i;

endmodule

// ===== design/sorted_priority_queue_prune_unit.sv =====
// Sorted priority queue with prune, built as a row of compare-and-shift cells.
//
// The queue holds up to DEPTH entries (primary key, secondary key, tag) in
// ascending (primary, secondary) order; equal keys keep arrival order. Each
// input word is one command: insert, pop head, or prune every entry whose
// primary key is at or above bound_value. Every cell compares its own entry
// with the broadcast key in parallel and either holds, takes the new entry,
// or takes its left or right neighbor's entry; one word can be accepted per
// clock when not stalled. Each accepted word gives exactly one output word
// in the next cycle, held in an output register; a new input word is taken
// whenever that register is empty or being drained in the same cycle, so
// in_stall_o only follows out_stall_i. Inserting into a full queue drops
// the largest entry (or the new one if it would go last) and sets overflow.
// Head fields are zero except for a pop of a non-empty queue. No clearing
// pass is needed after reset: only the fill count and out_valid_o reset.
module sorted_priority_queue_prune_unit import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  spq_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output spq_out_t out_word_o
);

  localparam int CNT_W = $clog2(DEPTH+1);

  logic             accept;
  spq_ctrl_t        ctrl;
  logic [CNT_W-1:0] count_q, count_d;
  logic             full;
  logic             out_valid_q;
  spq_out_t         out_word_q, result;

  spq_entry_t       ent [DEPTH];
  logic [DEPTH-1:0] gt, lt, cut;
  logic             cut_any;
  logic [CNT_W-1:0] cut_idx;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign ctrl.cmd             = in_word_i.command;
  assign ctrl.entry.primary   = in_word_i.primary_key;
  assign ctrl.entry.secondary = in_word_i.secondary_key;
  assign ctrl.entry.tag       = in_word_i.entry_tag;
  assign ctrl.bound           = in_word_i.bound_value;

  assign full = (count_q == CNT_W'(DEPTH));

  // cell row; cell 0 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk_i         (clk_i),
      .en_i          (accept),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .left_entry_i  ((i == 0) ? ent[0] : ent[(i == 0) ? 0 : i-1]),
      .left_gt_i     ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
      .left_lt_i     ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i-1]),
      .right_entry_i (ent[(i == DEPTH-1) ? i : i+1]),
      .entry_o       (ent[i]),
      .gt_o          (gt[i]),
      .lt_o          (lt[i]),
      .cut_o         (cut[i])
    );
  end

  spq_cut_enc #(
    .DEPTH (DEPTH)
  ) u_cut_enc (
    .cut_i (cut),
    .any_o (cut_any),
    .idx_o (cut_idx)
  );

  // next fill count and result word
  always_comb begin
    count_d = count_q;
    result  = '0;
    case (in_word_i.command)
      CMD_INSERT: begin
        if (full) begin
          result.overflow = 1'b1;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (count_q != '0) begin
          count_d               = count_q - CNT_W'(1);
          result.head_valid     = 1'b1;
          result.head_tag       = ent[0].tag;
          result.head_primary   = ent[0].primary;
          result.head_secondary = ent[0].secondary;
        end
      end
      CMD_PRUNE: begin
        if (cut_any) begin
          count_d = cut_idx;
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
    result.entry_count = COUNT_BITS'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
